// File: hdl/assert_macros.svh
// Assertion macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/sfd_pkg.sv
package sfd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int ADDR_W = IDX_W + 1;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] END_RESET = 8'hEF;

  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_END = 1'b1;

  typedef struct packed {
    logic en;
    logic [ADDR_W-1:0] addr;
    logic [15:0] data;
  } wr_t;

  typedef struct packed {
    logic bank;
    logic [CNT_W-1:0] count;
    logic ovf;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

// File: hdl/sfd_front.sv
module sfd_front (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] header_byte,
  input  logic [7:0] end_byte,
  input  logic s_valid,
  output logic s_ready,
  input  logic [7:0] s_data,
  output sfd_pkg::wr_t wr,
  output logic push,
  output sfd_pkg::cmd_t cmd,
  input  sfd_pkg::done_t done
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_HIGH,
    PH_LOW,
    PH_END
  } phase_t;

  localparam logic [7:0] DEPTH8 = 8'(STORE_DEPTH);

  phase_t phase;
  logic [7:0] frame_length;
  logic [7:0] samples_seen;
  logic [7:0] high_half;
  logic wbank;
  logic [1:0] busy;
  logic [1:0] busy_next;
  logic [7:0] seen_inc;
  logic accept;

  assign s_ready = !busy[wbank];
  assign accept = s_valid && s_ready;
  assign seen_inc = (samples_seen != 8'hFF) ? samples_seen + 8'd1 : samples_seen;

  assign wr.en = accept && (phase == PH_LOW) && (samples_seen < DEPTH8);
  assign wr.addr = {wbank, samples_seen[IDX_W-1:0]};
  assign wr.data = {high_half, s_data};

  assign push = accept && (phase == PH_END) && (s_data == end_byte);
  assign cmd.bank = wbank;
  assign cmd.count = (samples_seen >= DEPTH8) ? CNT_W'(STORE_DEPTH)
                                              : samples_seen[CNT_W-1:0];
  assign cmd.ovf = samples_seen > DEPTH8;

  always_comb begin
    busy_next = busy;
    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      frame_length <= 8'd0;
      samples_seen <= 8'd0;
      high_half <= 8'd0;
      wbank <= 1'b0;
      busy <= 2'b00;
    end else begin
      busy <= busy_next;
      if (accept) begin
        unique case (phase)
          PH_LEN: begin
            frame_length <= s_data;
            samples_seen <= 8'd0;
            phase <= PH_HIGH;
          end
          PH_HIGH: begin
            high_half <= s_data;
            phase <= PH_LOW;
          end
          PH_LOW: begin
            samples_seen <= seen_inc;
            phase <= (seen_inc >= frame_length) ? PH_END : PH_HIGH;
          end
          PH_END: begin
            if (push) begin
              wbank <= !wbank;
            end
            phase <= PH_HUNT;
          end
          PH_HUNT: begin
            phase <= (s_data == header_byte) ? PH_LEN : PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/sfd_queue.sv
module sfd_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  sfd_pkg::cmd_t push_cmd,
  input  logic pop,
  output logic empty,
  output sfd_pkg::cmd_t head
);
  import sfd_pkg::*;

  cmd_t slots [2];
  logic wptr;
  logic rptr;
  logic [1:0] fill;

  assign empty = (fill == 2'd0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        2'b00, 2'b11: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/sfd_back.sv
module sfd_back (
  input  logic clk,
  input  logic rst,
  input  sfd_pkg::wr_t wr,
  input  logic q_empty,
  input  sfd_pkg::cmd_t q_head,
  output logic pop,
  output sfd_pkg::done_t done,
  output logic m_valid,
  input  logic m_ready,
  output logic [23:0] m_data,
  output logic m_last
);
  import sfd_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } bstate_t;

  logic [15:0] mem [2*STORE_DEPTH];
  bstate_t state;
  logic bank;
  logic [CNT_W-1:0] count;
  logic ovf;
  logic [IDX_W-1:0] idx;
  logic [15:0] rdata;
  logic is_last;

  assign pop = (state == B_IDLE) && !q_empty;
  assign is_last = CNT_W'({1'b0, idx} + CNT_W'(1)) == count;
  assign m_valid = (state == B_SHOW);
  assign m_last = is_last;
  assign m_data = {1'b0, ovf, 6'(idx), rdata};
  assign done.valid = m_valid && m_ready && is_last;
  assign done.bank = bank;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (state == B_READ) begin
      rdata <= mem[{bank, idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      bank <= 1'b0;
      count <= '0;
      ovf <= 1'b0;
      idx <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop) begin
            bank <= q_head.bank;
            count <= q_head.count;
            ovf <= q_head.ovf;
            idx <= '0;
            state <= B_READ;
          end
        end
        B_READ: begin
          state <= B_SHOW;
        end
        B_SHOW: begin
          if (m_ready) begin
            if (is_last) begin
              state <= B_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= B_READ;
            end
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/sample_frame_deframer.sv
// Byte-stream frame parser for 16-bit samples.
// Input: s_axis carries one received byte per transfer. A frame is the
// header byte, a length byte, big-endian sample pairs and the end byte.
// Output: m_axis carries one sample per transfer for each frame whose end
// byte matched; tlast marks the final sample, tdata also gives the sample
// index and the overflow flag. Frames with a wrong end byte yield nothing.
// Configuration: APB registers header_byte at 0x0 and end_byte at 0x4.
// Timing: a byte is accepted whenever s_axis_tready is high. After the end
// byte the back end pops the frame from the queue; each sample passes its
// read state, then is offered in its show state until tready is high. Two
// sample banks of 64 entries let the parser fill one frame while the
// other is sent out; the parser drops tready while both banks hold
// committed frames that have not been fully transferred.
// When the receiver stalls, the current sample holds on m_axis and the
// parser keeps taking bytes until both banks are occupied.
// Reset: synchronous, active high; the parser returns to header hunt,
// the queue empties, registers return to 0xAA and 0xEF.
module sample_frame_deframer (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] sample, [21:16] sample_index,
                                     // [22] overflowed, [23] zero
  output logic m_axis_tlast,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import sfd_pkg::*;

  logic [7:0] header_byte;
  logic [7:0] end_byte;
  wr_t wr;
  logic push;
  cmd_t cmd;
  done_t done;
  logic pop;
  logic q_empty;
  cmd_t q_head;

  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == REG_END) ? end_byte : header_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_RESET;
      end_byte <= END_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEADER) begin
        header_byte <= pwdata[7:0];
      end else begin
        end_byte <= pwdata[7:0];
      end
    end
  end

  sfd_front u_front (
    .clk(clk),
    .rst(rst),
    .header_byte(header_byte),
    .end_byte(end_byte),
    .s_valid(s_axis_tvalid),
    .s_ready(s_axis_tready),
    .s_data(s_axis_tdata),
    .wr(wr),
    .push(push),
    .cmd(cmd),
    .done(done)
  );

  sfd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(cmd),
    .pop(pop),
    .empty(q_empty),
    .head(q_head)
  );

  sfd_back u_back (
    .clk(clk),
    .rst(rst),
    .wr(wr),
    .q_empty(q_empty),
    .q_head(q_head),
    .pop(pop),
    .done(done),
    .m_valid(m_axis_tvalid),
    .m_ready(m_axis_tready),
    .m_data(m_axis_tdata),
    .m_last(m_axis_tlast)
  );

endmodule

// File: hdl/sfd_checker.sv
`include "assert_macros.svh"

module sfd_checker (
  input logic clk,
  input logic rst,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic m_axis_tlast,
  input logic pready
);
  import sfd_pkg::*;

  `ASSERT_SAME(a_pready_high, clk, rst, 1'b1, pready)
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `ASSERT_NEXT(a_gap_after_transfer, clk, rst, m_axis_tvalid && m_axis_tready,
    !m_axis_tvalid)
  `ASSERT_SAME(a_ovf_last_index, clk, rst,
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[22],
    m_axis_tdata[21:16] == 6'(STORE_DEPTH - 1))

endmodule

bind sample_frame_deframer sfd_checker u_sfd_checker (.*);

// File: sim/sample_frame_deframer_checker.sv
module sample_frame_deframer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [15:0] sample, [21:16] sample_index,
                                      // [22] overflowed, [23] zero
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import sfd_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_HIGH,
    ST_LOW,
    ST_CLOSE
  } parse_state_e;

  typedef struct packed {
    logic [15:0] sample;
    logic [5:0]  index;
    logic        last;
    logic        ovf;
  } sample_beat_t;

  localparam logic [2:0] ADDR_HEADER = {REG_HEADER, 2'b00};
  localparam logic [2:0] ADDR_END = {REG_END, 2'b00};

  logic [7:0] header_val;
  logic [7:0] end_val;
  parse_state_e parse_state;
  logic [7:0] length_val;
  logic [7:0] seen_count;
  logic [7:0] high_byte;
  logic [15:0] sample_store [STORE_DEPTH];
  sample_beat_t expected_samples [$];

  initial begin
    errors = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int count;
    sample_beat_t beat;
    case (parse_state)
      ST_LEN: begin
        length_val = b;
        seen_count = 8'd0;
        parse_state = ST_HIGH;
      end
      ST_HIGH: begin
        high_byte = b;
        parse_state = ST_LOW;
      end
      ST_LOW: begin
        if (seen_count < STORE_DEPTH) sample_store[seen_count[IDX_W-1:0]] = {high_byte, b};
        if (seen_count != 8'hFF) seen_count = seen_count + 8'd1;
        parse_state = (seen_count >= length_val) ? ST_CLOSE : ST_HIGH;
      end
      ST_CLOSE: begin
        if (b == end_val) begin
          count = (seen_count < STORE_DEPTH) ? int'(seen_count) : STORE_DEPTH;
          for (int k = 0; k < count; k++) begin
            beat.sample = sample_store[IDX_W'(k)];
            beat.index = 6'(k);
            beat.last = (k == count - 1);
            beat.ovf = (seen_count > STORE_DEPTH);
            expected_samples.push_back(beat);
          end
        end
        parse_state = ST_HUNT;
      end
      default: begin
        parse_state = (b == header_val) ? ST_LEN : ST_HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    sample_beat_t want;
    logic [31:0] reg_want;
    bit reg_known;
    if (rst) begin
      header_val = HEADER_RESET;
      end_val = END_RESET;
      parse_state = ST_HUNT;
      length_val = 8'd0;
      seen_count = 8'd0;
      high_byte = 8'd0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_known = 1'b1;
        if (paddr == ADDR_HEADER) reg_want = {24'd0, header_val};
        else if (paddr == ADDR_END) reg_want = {24'd0, end_val};
        else reg_known = 1'b0;
        if (pwrite) begin
          if (paddr == ADDR_HEADER) header_val = pwdata[7:0];
          else if (paddr == ADDR_END) end_val = pwdata[7:0];
        end else if (reg_known && prdata !== reg_want) begin
          report_mismatch($sformatf("read addr %0d got %h want %h", paddr, prdata, reg_want));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %h with nothing pending", m_axis_tdata));
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata[15:0] !== want.sample)
            report_mismatch($sformatf("sample got %h want %h", m_axis_tdata[15:0], want.sample));
          if (m_axis_tdata[21:16] !== want.index)
            report_mismatch($sformatf("index got %0d want %0d", m_axis_tdata[21:16],
                                      want.index));
          if (m_axis_tdata[22] !== want.ovf)
            report_mismatch($sformatf("overflow got %b want %b", m_axis_tdata[22], want.ovf));
          if (m_axis_tdata[23] !== 1'b0)
            report_mismatch("pad bit of tdata not zero");
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("tlast got %b want %b at index %0d", m_axis_tlast,
                                      want.last, want.index));
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
    end
    pending <= expected_samples.size();
  end

endmodule

// File: sim/sample_frame_deframer_tb.sv
module sample_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [2:0] ADDR_HEADER = {REG_HEADER, 2'b00};
  localparam logic [2:0] ADDR_END = {REG_END, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;          // [15:0] sample, [21:16] sample_index,
                                      // [22] overflowed, [23] zero
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int bytes_sent = 0;
  int idle_cycles = 0;
  logic hold_rx = 1'b0;
  logic pressure_go = 1'b0;
  logic rx_fast = 1'b0;
  logic tx_fast = 1'b0;
  logic [7:0] header_cfg = HEADER_RESET;
  logic [7:0] end_cfg = END_RESET;

  sample_frame_deframer dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  sample_frame_deframer_checker sample_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .errors(errors),
    .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                 || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
      gap = rx_fast ? 0 : $urandom_range(0, 12);
      if (gap != 0 || hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  initial begin : pressure
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic send_byte(input logic [7:0] value);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_fast = !tx_fast;
    gap = tx_fast ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit close_ok);
    int pairs;
    logic [7:0] close_val;
    pairs = (len == 0) ? 1 : len;
    send_byte(header_cfg);
    send_byte(8'(len));
    repeat (pairs) begin
      send_byte(8'($urandom));
      send_byte(8'($urandom));
    end
    close_val = end_cfg;
    if (!close_ok) while (close_val == end_cfg) close_val = 8'($urandom);
    send_byte(close_val);
  endtask

  task automatic random_traffic(input int nbytes);
    int stop_at;
    int pick;
    int len;
    logic [7:0] noise;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 8);
      if (pick < 70) begin
        send_frame(len, 1'b1);
      end else if (pick < 84) begin
        send_frame(len, 1'b0);
      end else if (pick < 90) begin
        // truncate: the next frame's bytes land in this one
        send_byte(header_cfg);
        send_byte(8'($urandom_range(2, 8)));
        send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          noise = 8'($urandom);
          if (noise != header_cfg) send_byte(noise);
        end
      end
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] hdr, input logic [7:0] endv);
    apb_access(1'b1, ADDR_HEADER, {24'd0, hdr});
    apb_access(1'b1, ADDR_END, {24'd0, endv});
    apb_access(1'b0, ADDR_HEADER, 32'd0);
    apb_access(1'b0, ADDR_END, 32'd0);
    header_cfg = hdr;
    end_cfg = endv;
  endtask

  initial begin : stimulus
    logic [7:0] directed [24];
    directed = '{
      8'h00, 8'hFF,
      8'hAA, 8'h00, 8'h12, 8'h34, 8'hEF,
      8'hAA, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hEF,
      8'hAA, 8'h01, 8'hAA, 8'hAA, 8'hEE,
      8'hAA, 8'h01, 8'hAA, 8'h55, 8'hEF
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_byte(directed[i]);
    send_frame(65, 1'b1);
    settle();
    apb_access(1'b0, ADDR_HEADER, 32'd0);
    apb_access(1'b0, ADDR_END, 32'd0);

    pressure_go = 1'b1;
    send_frame(2, 1'b1);
    send_frame(2, 1'b1);
    random_traffic(4);
    settle();

    set_config(8'h00, 8'hFF);
    random_traffic(6);
    settle();
    set_config(8'($urandom), 8'($urandom));
    random_traffic(6);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
